[rtl/acm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types, constants and AES-128 round functions for the CBC-MAC block.
// ----------------------------------------------------------------------------
package acm_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int BLOCK_W     = 8 * BLOCK_BYTES;
  localparam int CNT_W       = $clog2(BLOCK_BYTES);
  localparam int CFG_IDX_W   = 2;
  localparam int NUM_ROUNDS  = 10;
  localparam int RND_W       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

  localparam logic [7:0] PAD_FULL = 8'h10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [63:0] mac_high;
    logic [63:0] mac_low;
  } out_t;

  // One block handed from the assembler to the cipher engine
  typedef struct packed {
    logic [BLOCK_W-1:0] blk;
    logic               last;
  } job_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round key from the current one; byte 0 sits in the top bits
  function automatic logic [BLOCK_W-1:0] key_next(input logic [BLOCK_W-1:0] rk,
                                                   input logic [7:0] rcon);
    logic [31:0] t;
    logic [31:0] n0, n1, n2, n3;
    t  = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    n0 = rk[127:96] ^ t;
    n1 = rk[95:64] ^ n0;
    n2 = rk[63:32] ^ n1;
    n3 = rk[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // One cipher round: sub bytes, shift rows, mix columns unless last, add key
  function automatic logic [BLOCK_W-1:0] aes_round(input logic [BLOCK_W-1:0] s,
                                                    input logic [BLOCK_W-1:0] rk,
                                                    input logic last_rnd);
    logic [7:0] t [BLOCK_BYTES];
    logic [7:0] u [BLOCK_BYTES];
    logic [7:0] a0, a1, a2, a3, all;
    logic [BLOCK_W-1:0] r;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      t[i] = SBOX[s[BLOCK_W-1-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        u[j + 4*c] = t[j + 4*((c + j) & 3)];
      end
    end
    if (!last_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0  = u[4*c];
        a1  = u[4*c+1];
        a2  = u[4*c+2];
        a3  = u[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        u[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        u[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        u[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        u[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      r[BLOCK_W-1-8*i -: 8] = u[i] ^ rk[BLOCK_W-1-8*i -: 8];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/acm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acm_front
// Byte assembler: gathers message bytes into blocks, pads the last block and
// pushes each finished block to the job queue.
// ----------------------------------------------------------------------------
module acm_front import acm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      push_o,
  output job_t      push_job_o,
  input  wire logic full_i
);

  logic [BLOCK_W-1:0] buf_q, buf_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               pend_q, pend_d;
  logic               acc;
  logic [BLOCK_W-1:0] filled, padded;
  logic [CNT_W-1:0]   cnt1;
  logic [CNT_W:0]     npad;

  assign in_ready_o = !pend_q && !full_i;
  assign acc        = in_valid_i && in_ready_o;

  // Insert the carried byte and pad from the new fill level
  always_comb begin
    filled = buf_q;
    if (in_data_i.has_byte) begin
      filled[BLOCK_W-1-8*cnt_q -: 8] = in_data_i.data_byte;
    end
    cnt1   = cnt_q + CNT_W'(in_data_i.has_byte);
    npad   = (CNT_W+1)'(BLOCK_BYTES) - {1'b0, cnt1};
    padded = filled;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (CNT_W'(i) >= cnt1) begin
        padded[BLOCK_W-1-8*i -: 8] = 8'(npad);
      end
    end
  end

  // Decide what goes to the queue this cycle
  always_comb begin
    buf_d           = buf_q;
    cnt_d           = cnt_q;
    pend_d          = pend_q;
    push_o          = 1'b0;
    push_job_o.blk  = padded;
    push_job_o.last = 1'b1;
    if (pend_q) begin
      if (!full_i) begin
        push_o          = 1'b1;
        push_job_o.blk  = {BLOCK_BYTES{PAD_FULL}};
        push_job_o.last = 1'b1;
        pend_d          = 1'b0;
      end
    end else if (acc) begin
      buf_d = filled;
      cnt_d = in_data_i.end_of_message ? '0 : cnt1;
      if (in_data_i.has_byte && (cnt_q == CNT_W'(BLOCK_BYTES - 1))) begin
        push_o          = 1'b1;
        push_job_o.blk  = filled;
        push_job_o.last = 1'b0;
        pend_d          = in_data_i.end_of_message;
      end else if (in_data_i.end_of_message) begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule
`default_nettype wire

[rtl/acm_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acm_fifo
// Two-entry job queue between the assembler and the cipher engine.
// ----------------------------------------------------------------------------
module acm_fifo import acm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_job_i,
  output logic      full_o,
  output logic      valid_o,
  output job_t      job_o,
  input  wire logic pop_i
);

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rp_q];
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (do_pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_job_i;
    end
  end

endmodule
`default_nettype wire

[rtl/acm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acm_back
// Cipher engine: one AES-128 round per cycle with round keys expanded on the
// fly, chaining value, and the MAC output register.
// ----------------------------------------------------------------------------
module acm_back import acm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [BLOCK_W-1:0] key_i,
  input  wire logic               job_valid_i,
  input  wire job_t               job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_t                    out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [RND_W-1:0]   rnd_q, rnd_d;
  logic [7:0]         rcon_q, rcon_d;
  logic               last_q, last_d;
  logic [BLOCK_W-1:0] st_q, st_d, rk_q, rk_d, chain_q, chain_d, rk_nx;
  logic               ov_q, ov_d;
  out_t               od_q, od_d;
  logic               slot_free;

  assign slot_free   = !ov_q || out_ready_i;
  assign pop_o       = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign rk_nx       = key_next(rk_q, rcon_q);

  // Sequence whitening, ten rounds, the chaining update and the MAC issue
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    rcon_d  = rcon_q;
    last_d  = last_q;
    st_d    = st_q;
    rk_d    = rk_q;
    chain_d = chain_q;
    ov_d    = ov_q && !out_ready_i;
    od_d    = od_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          st_d    = chain_q ^ job_i.blk ^ key_i;
          rk_d    = key_i;
          rcon_d  = 8'h01;
          rnd_d   = RND_W'(1);
          last_d  = job_i.last;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        st_d   = aes_round(st_q, rk_nx, rnd_q == RND_W'(NUM_ROUNDS));
        rk_d   = rk_nx;
        rcon_d = xtime(rcon_q);
        rnd_d  = rnd_q + RND_W'(1);
        if (rnd_q == RND_W'(NUM_ROUNDS)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!last_q) begin
          chain_d = st_q;
          state_d = S_IDLE;
        end else if (slot_free) begin
          ov_d    = 1'b1;
          od_d    = out_t'(st_q);
          chain_d = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chain_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      chain_q <= chain_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q  <= rnd_d;
    rcon_q <= rcon_d;
    last_q <= last_d;
    st_q   <= st_d;
    rk_q   <= rk_d;
    od_q   <= od_d;
  end

  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (rnd_q >= RND_W'(1) && rnd_q <= RND_W'(NUM_ROUNDS)))
    else $error("round counter out of range");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && job_valid_i) |=> (state_q == S_RUN && rnd_q == RND_W'(1)))
    else $error("job taken without starting rounds");

  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && rnd_q == RND_W'(NUM_ROUNDS)) |=> (state_q == S_DONE))
    else $error("last round did not finish the block");

  a_mac_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && last_q && slot_free) |=> (chain_q == '0 && ov_q))
    else $error("MAC issue did not clear chain");

endmodule
`default_nettype wire

[rtl/aes128_cbc_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_cbc_mac
// AES-128 CBC-MAC over a byte stream with PKCS#7-style final padding.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle inside a message while the queue has room
//   and no padding block is pending; the engine handles one block at a time
//   (load with whitening, ten rounds in the shared round unit, chain update).
//   When the end byte completes a block, a full padding block follows it before
//   the MAC is presented.
// Reset: asynchronous, clears key, chaining value, fill count and queue.
module aes128_cbc_mac import acm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [63:0]          cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_t                      out_data_o
);

  logic [63:0] key_high_q, key_low_q;
  logic        push, full, job_valid, pop;
  job_t        push_job, job;

  // Hold key registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        REG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  acm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_job_o (push_job),
    .full_i     (full)
  );

  acm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .valid_o    (job_valid),
    .job_o      (job),
    .pop_i      (pop)
  );

  acm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       ({key_high_q, key_low_q}),
    .job_valid_i (job_valid),
    .job_i       (job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AES-128 CBC-MAC block. Messages are fed as byte
// beats, each expected MAC is computed by a local cipher model on acceptance,
// and every MAC beat is compared against the oldest outstanding prediction.
// Key settings and handshake idling change from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
  import acm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 3000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [63:0]          cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_t                 out_data_o;

  // Byte beats waiting to be sent, MACs waiting to arrive
  in_t  beat_q[$];
  out_t mac_q[$];

  // Local copy of the block's key and chaining state
  logic [127:0] key_model;
  logic [127:0] chain_model;
  logic [127:0] block_model;
  logic [3:0]   fill_model;

  logic [7:0] sub_tab [256];
  int send_idle_pct;
  int recv_stall_pct;
  int pushed_cnt;
  int accepted_cnt;
  int fail_cnt;
  int quiet_cnt;

  aes128_cbc_mac i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  // S-box entry from the field inverse (x^254) and the affine map
  function automatic logic [7:0] sbox_entry(input logic [7:0] x);
    logic [7:0] inv, b;
    inv = 8'h01;
    for (int k = 0; k < 254; k++) inv = gf_mul(inv, x);
    b = inv;
    return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
             ^ {b[3:0], b[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] pt,
                                                 input logic [127:0] key);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] tmp [16];
    logic [7:0] t [4];
    logic [7:0] rcon, first, a0, a1, a2, a3, all;
    logic [127:0] res;
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      s[i]  = pt[127-8*i -: 8] ^ rk[i];
    end
    // Expand the key schedule
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = rk[i-4+j];
      if ((i % 16) == 0) begin
        first = t[0];
        t[0] = sub_tab[t[1]] ^ rcon;
        t[1] = sub_tab[t[2]];
        t[2] = sub_tab[t[3]];
        t[3] = sub_tab[first];
        rcon = gf_dbl(rcon);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ t[j];
    end
    // Ten rounds, no column mixing in the last
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) tmp[i] = sub_tab[s[i]];
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) s[j+4*c] = tmp[j + 4*((c+j) % 4)];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
          s[4*c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
          s[4*c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
          s[4*c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[16*r + i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  // Advance the MAC state by one accepted beat; queue a MAC on message end
  function automatic void absorb_beat(input in_t b);
    logic [7:0] pad;
    out_t mac;
    if (b.has_byte) begin
      block_model[127-8*fill_model -: 8] = b.data_byte;
      fill_model = fill_model + 4'd1;
      if (fill_model == 4'd0) chain_model = encrypt_block(chain_model ^ block_model, key_model);
    end
    if (b.end_of_message) begin
      pad = 8'd16 - {4'd0, fill_model};
      for (int i = 0; i < 16; i++)
        if (i >= fill_model) block_model[127-8*i -: 8] = pad;
      chain_model = encrypt_block(chain_model ^ block_model, key_model);
      mac.mac_high = chain_model[127:64];
      mac.mac_low  = chain_model[63:0];
      mac_q.push_back(mac);
      chain_model = '0;
      fill_model  = '0;
    end
  endfunction

  // Sender: hold the beat until taken, then fetch the next one
  always @(posedge clk_i) begin
    logic take;
    logic nxt_valid;
    take      = in_valid_i && in_ready_o;
    nxt_valid = in_valid_i && !take;
    if (take) begin
      absorb_beat(in_data_i);
      accepted_cnt++;
    end
    if (rst_ni && !nxt_valid && beat_q.size() > 0 &&
        $urandom_range(0, 99) >= send_idle_pct) begin
      in_data_i <= beat_q.pop_front();
      nxt_valid = 1'b1;
    end
    in_valid_i <= nxt_valid;
  end

  // Receiver: check each MAC beat, stall at random
  always @(posedge clk_i) begin
    out_t exp_mac;
    if (out_valid_o && out_ready_i) begin
      if (mac_q.size() == 0) begin
        $display("%0t: MAC expected none actual %h", $realtime, out_data_o);
        fail_cnt++;
      end else begin
        exp_mac = mac_q.pop_front();
        if (out_data_o.mac_high !== exp_mac.mac_high) begin
          $display("%0t: mac_high expected %h actual %h", $realtime,
                   exp_mac.mac_high, out_data_o.mac_high);
          fail_cnt++;
        end
        if (out_data_o.mac_low !== exp_mac.mac_low) begin
          $display("%0t: mac_low expected %h actual %h", $realtime,
                   exp_mac.mac_low, out_data_o.mac_low);
          fail_cnt++;
        end
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cnt = 0;
    else quiet_cnt++;
    if (quiet_cnt >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_KEY_HIGH) key_model[127:64] = val;
    else if (idx == REG_KEY_LOW) key_model[63:0] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_beat(input logic [7:0] d, input logic has, input logic eom);
    in_t b;
    b.data_byte      = d;
    b.has_byte       = has;
    b.end_of_message = eom;
    beat_q.push_back(b);
    pushed_cnt++;
  endtask

  // One message: random bytes, optional no-op beats, end joined or separate
  task automatic push_message(input int len, input bit join_end, input int noise_pct);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < noise_pct)
        push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_beat(8'($urandom_range(0, 255)), 1'b1, join_end && (k == len - 1));
    end
    if (!join_end || len == 0) push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Wait until every beat is taken and every MAC has come, then let it settle
  task automatic drain;
    do @(negedge clk_i);
    while (accepted_cnt != pushed_cnt || mac_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_random(input int count);
    int target;
    target = pushed_cnt + count;
    while (pushed_cnt < target) begin
      if ($urandom_range(0, 99) < 10) push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      else if ($urandom_range(0, 99) < 85)
        push_message(int'($urandom_range(0, 40)), 1'($urandom_range(0, 1)), 8);
      else push_message(int'($urandom_range(41, 80)), 1'($urandom_range(0, 1)), 8);
    end
  endtask

  initial begin
    key_model   = '0;
    chain_model = '0;
    block_model = '0;
    fill_model  = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pushed_cnt   = 0;
    accepted_cnt = 0;
    fail_cnt     = 0;
    quiet_cnt    = 0;
    for (int i = 0; i < 256; i++) sub_tab[i] = sbox_entry(i[7:0]);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty message, byte with end, no-op, end byte filling a block, empty message
    push_beat(8'hff, 1'b0, 1'b1);
    push_beat(8'hff, 1'b1, 1'b1);
    push_beat(8'h5a, 1'b0, 1'b0);
    for (int k = 0; k < 16; k++) push_beat(k[0] ? 8'hff : 8'h00, 1'b1, k == 15);
    push_beat(8'h00, 1'b0, 1'b1);
    drain();

    // All-ones key, spare indexes ignored, sender idling
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_SPARE_A, 64'h0123_4567_89ab_cdef);
    write_reg(REG_SPARE_B, '1);
    send_idle_pct = 56;
    run_random(160);
    drain();

    write_reg(REG_KEY_HIGH, {$urandom, $urandom});
    write_reg(REG_KEY_LOW, {$urandom, $urandom});
    send_idle_pct  = 0;
    recv_stall_pct = 56;
    run_random(160);
    drain();

    write_reg(REG_KEY_HIGH, {$urandom, $urandom});
    write_reg(REG_KEY_LOW, '0);
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    run_random(160);
    drain();

    write_reg(REG_KEY_HIGH, '0);
    write_reg(REG_KEY_LOW, {$urandom, $urandom});
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(160);
    drain();

    if (fail_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/acm_pkg.sv
rtl/acm_front.sv
rtl/acm_fifo.sv
rtl/acm_back.sv
rtl/aes128_cbc_mac.sv
sim/tb_top.sv
